// ===== rtl/core/afne_pkg.sv =====
// ----------------------------------------------------------------------------
// ADAT frame NRZI encoder package
// Frame layout constants and the per-channel lane result type.
// ----------------------------------------------------------------------------
package afne_pkg;

    localparam int NUM_CH      = 8;
    localparam int SAMPLE_W    = 24;
    localparam int NIBBLES     = SAMPLE_W / 4;
    localparam int CH_BITS     = 1 + NIBBLES * 5 - 1;
    localparam int SYNC_BITS   = 10;
    localparam int FRAME_BITS  = 256;
    localparam int PAD_BITS    = FRAME_BITS - SYNC_BITS - NUM_CH * CH_BITS;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = FRAME_BITS / BYTE_W;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int IN_W        = NUM_CH * SAMPLE_W;

    // Line bits of one channel relative to a starting level of zero, and the
    // overall toggle parity of that channel.
    typedef struct packed {
        logic [CH_BITS-1:0] rel;
        logic               parity;
    } lane_t;

endpackage

// ===== rtl/core/afne_lane.sv =====
// ----------------------------------------------------------------------------
// ADAT encoder channel lane
// Builds the 30-bit pre-coding pattern of one channel and its NRZI line bits
// relative to a starting level of zero.
// ----------------------------------------------------------------------------
module afne_lane
    import afne_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    output lane_t               lane
);

    logic [CH_BITS-1:0] pattern;
    logic [CH_BITS-1:0] rel;

    always_comb
    begin
        pattern    = '0;
        pattern[0] = 1'b1;
        for (int n = 0; n < NIBBLES; n++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                pattern[1 + 5 * n + b] = sample[SAMPLE_W - 1 - 4 * n - b];
            end
            if (n < NIBBLES - 1)
            begin
                pattern[5 + 5 * n] = 1'b1;
            end
        end

        // Running XOR gives the level after each bit, starting from zero.
        rel[0] = pattern[0];
        for (int j = 1; j < CH_BITS; j++)
        begin
            rel[j] = rel[j-1] ^ pattern[j];
        end
    end

    assign lane.rel    = rel;
    assign lane.parity = rel[CH_BITS-1];

endmodule

// ===== rtl/core/afne_merge.sv =====
// ----------------------------------------------------------------------------
// ADAT encoder lane merge
// Chains the lane parities to find each channel's starting level and
// assembles the full 256-bit line frame with sync and pad.
// ----------------------------------------------------------------------------
module afne_merge
    import afne_pkg::*;
(
    input  lane_t                 lanes [NUM_CH],
    input  logic                  level_in,
    output logic [FRAME_BITS-1:0] frame,
    output logic                  level_out
);

    logic lvl;

    always_comb
    begin
        // The sync's leading one toggles the incoming level.
        lvl = ~level_in;
        frame = '0;
        frame[SYNC_BITS-1:0] = {SYNC_BITS{lvl}};
        for (int c = 0; c < NUM_CH; c++)
        begin
            frame[SYNC_BITS + CH_BITS * c +: CH_BITS] = lanes[c].rel ^ {CH_BITS{lvl}};
            lvl = lvl ^ lanes[c].parity;
        end
        frame[FRAME_BITS-1 -: PAD_BITS] = {PAD_BITS{lvl}};
        level_out = lvl;
    end

endmodule

// ===== rtl/core/afne_serializer.sv =====
// ----------------------------------------------------------------------------
// ADAT encoder byte serializer
// Holds one coded frame and sends it out one byte per beat, earliest byte
// first, marking the last byte of the frame.
// ----------------------------------------------------------------------------
module afne_serializer
    import afne_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FRAME_BITS-1:0] frame,
    input  logic                  load,
    output logic                  load_ok,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,
    output logic                  m_tlast
);

    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  last;
    logic                  beat;

    assign last     = (cnt_reg == CNT_W'(FRAME_BYTES - 1));
    assign beat     = valid_reg && m_tready;
    // A new frame may enter as soon as the last byte of the current one goes.
    assign load_ok  = !valid_reg || (beat && last);
    assign m_tvalid = valid_reg;
    assign m_tdata  = frame_reg[BYTE_W-1:0];
    assign m_tlast  = last;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load)
        begin
            frame_next = frame;
            cnt_next   = '0;
            valid_next = 1'b1;
        end
        else if (beat)
        begin
            frame_next = frame_reg >> BYTE_W;
            cnt_next   = cnt_reg + 1'b1;
            if (last)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

// ===== rtl/core/adat_frame_nrzi_encoder.sv =====
// ----------------------------------------------------------------------------
// ADAT frame NRZI encoder
// Eight-channel sample frame in, 32 NRZI-coded line bytes out.
// ----------------------------------------------------------------------------
// Each input beat carries eight 24-bit samples and produces one 256-bit
// NRZI line frame, delivered as 32 output beats of one byte each, earliest
// line bit in bit 0, with tlast on the 32nd byte. The byte-wide output port
// sets the throughput. Eight channel lanes code their samples in parallel
// into a register stage; the merge applies the carried line level as the
// frame enters the serializer, so the first byte is offered from the
// serializer's frame register after the frame has passed the lane register
// stage. A second frame is taken in while the previous one is still being
// sent. The line level resets to zero and carries across frames.
// ----------------------------------------------------------------------------
module adat_frame_nrzi_encoder
    import afne_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // sample_ch0 .. sample_ch7, 24 bits each
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // frame_byte
    output logic              m_tlast    // last_byte
);

    lane_t                 lanes     [NUM_CH];
    lane_t                 lanes_reg [NUM_CH];
    logic                  stg_valid_reg;
    logic                  stg_valid_next;
    logic                  level_reg;
    logic                  level_next;
    logic                  level_out;
    logic [FRAME_BITS-1:0] frame;
    logic                  load;
    logic                  load_ok;
    logic                  in_beat;

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        afne_lane u_lane (
            .sample (s_tdata[SAMPLE_W * c +: SAMPLE_W]),
            .lane   (lanes[c])
        );
    end

    afne_merge u_merge (
        .lanes     (lanes_reg),
        .level_in  (level_reg),
        .frame     (frame),
        .level_out (level_out)
    );

    afne_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .load     (load),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign load     = stg_valid_reg && load_ok;
    assign s_tready = !stg_valid_reg || load;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (in_beat)
        begin
            stg_valid_next = 1'b1;
        end
        else if (load)
        begin
            stg_valid_next = 1'b0;
        end
        level_next = load ? level_out : level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            level_reg     <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            lanes_reg <= lanes;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// ADAT frame NRZI encoder testbench
// Sends frames of eight samples, predicts the NRZI line bytes and checks them.
// ----------------------------------------------------------------------------
// The line checker builds each 256-bit frame from the samples of an accepted
// input beat. The frame holds the sync, the eight channels with their
// separator ones, and the pad. It codes the frame NRZI with a line level
// that it carries across frames, and it queues the 32 bytes it expects. Every
// output beat is compared with the oldest queued byte. A directed set of
// frames is sent first: silence, full scale, bit patterns and single loud
// channels. Random frames follow, with mixed sample shapes. Both sides stall
// at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module testbench;
    import afne_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_FRAMES = 142;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};

    typedef struct {
        logic [BYTE_W-1:0] line_byte;
        logic              last;
    } line_byte_t;

    class nrzi_line_checker;
        line_byte_t          expected_bytes[$];
        logic                level;
        logic [FRAME_BITS-1:0] line_bits;
        int                  bit_pos;
        int                  errors;
        int                  byte_index;

        function new();
            level      = 1'b0;
            errors     = 0;
            byte_index = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void shift_bit(logic b);
            if (b)
                level = ~level;
            line_bits[bit_pos] = level;
            bit_pos++;
        endfunction

        // Codes one frame and queues the bytes it produces on the line.
        function void note_frame(logic [IN_W-1:0] samples);
            logic [SAMPLE_W-1:0] s;
            line_byte_t          lb;

            line_bits = '0;
            bit_pos   = 0;
            shift_bit(1'b1);
            for (int k = 1; k < SYNC_BITS; k++)
                shift_bit(1'b0);
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s = samples[ch*SAMPLE_W +: SAMPLE_W];
                shift_bit(1'b1);
                for (int nib = 0; nib < NIBBLES; nib++)
                begin
                    for (int b = 3; b >= 0; b--)
                        shift_bit(s[SAMPLE_W - 4 - 4*nib + b]);
                    if (nib < NIBBLES - 1)
                        shift_bit(1'b1);
                end
            end
            while (bit_pos < FRAME_BITS)
                shift_bit(1'b0);
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                lb.line_byte = line_bits[k*BYTE_W +: BYTE_W];
                lb.last      = (k == FRAME_BYTES - 1);
                expected_bytes.push_back(lb);
            end
        endfunction

        task report(string what, int want, int got);
            $display("mismatch at output beat %0d: %s expected %0h got %0h",
                     byte_index, what, want, got);
            errors++;
        endtask

        task check_byte(logic [BYTE_W-1:0] data, logic last);
            line_byte_t lb;

            if (expected_bytes.size() == 0)
            begin
                report("unexpected beat, data", 0, data);
            end
            else
            begin
                lb = expected_bytes.pop_front();
                if (data !== lb.line_byte)
                    report("frame_byte", lb.line_byte, data);
                if (last !== lb.last)
                    report("last_byte", lb.last, last);
            end
            byte_index++;
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;

    nrzi_line_checker line_checker;
    bit               tx_burst = 1'b0;
    bit               rx_burst = 1'b0;
    int               cycles = 0;

    adat_frame_nrzi_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles == CYCLE_LIMIT)
            begin
                $display("[adat_frame_nrzi_encoder] ERROR");
                $finish;
            end
        end
    end

    function automatic int draw_gap(bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Sample shapes that reach the extremes more often than plain random.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] s;

        case ($urandom_range(0, 7))
            0: s = '0;
            1: s = FULL_SCALE;
            2: s = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            3: s = SAMPLE_W'(4'hF) << (4 * $urandom_range(0, NIBBLES - 1));
            default: s = SAMPLE_W'($urandom_range(0, 32'hFF_FFFF));
        endcase
        return s;
    endfunction

    task send_frame(logic [IN_W-1:0] samples);
        int gap;

        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= samples;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        line_checker.note_frame(samples);
    endtask

    task drain_line();
        s_tvalid <= 1'b0;
        while (line_checker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] fill_frame(logic [SAMPLE_W-1:0] s);
        return {NUM_CH{s}};
    endfunction

    // Receiver: holds tready low for a random number of cycles per beat.
    initial
    begin
        int stall;
        int beats;

        beats = 0;
        wait (rst_n);
        forever
        begin
            if (beats % 48 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            stall = draw_gap(rx_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            line_checker.check_byte(m_tdata, m_tlast);
            beats++;
        end
    end

    initial
    begin
        logic [IN_W-1:0]     frame;
        logic [SAMPLE_W-1:0] one_nibble;

        line_checker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Silence twice, so the carried level is seen on an unchanged frame.
        send_frame('0);
        send_frame('0);
        send_frame(fill_frame(FULL_SCALE));
        send_frame(fill_frame(24'hAAAAAA));
        send_frame(fill_frame(24'h555555));
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            frame = '0;
            frame[ch*SAMPLE_W +: SAMPLE_W] = FULL_SCALE;
            send_frame(frame);
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            one_nibble = SAMPLE_W'(4'hF) << (4 * (ch % NIBBLES));
            frame[ch*SAMPLE_W +: SAMPLE_W] = (ch < NIBBLES) ? one_nibble : SAMPLE_W'(ch);
        end
        send_frame(frame);
        for (int ch = 0; ch < NUM_CH; ch++)
            frame[ch*SAMPLE_W +: SAMPLE_W] = ch[0] ? '0 : FULL_SCALE;
        send_frame(frame);
        send_frame(fill_frame(24'h800001));
        send_frame(fill_frame(24'h123456));
        drain_line();

        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n % 20 == 0)
                tx_burst = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_FRAMES / 2)
                drain_line();
            for (int ch = 0; ch < NUM_CH; ch++)
                frame[ch*SAMPLE_W +: SAMPLE_W] = random_sample();
            send_frame(frame);
        end

        drain_line();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (line_checker.errors == 0 && line_checker.pending() == 0)
            $display("[adat_frame_nrzi_encoder] OK");
        else
            $display("[adat_frame_nrzi_encoder] ERROR");
        $finish;
    end

endmodule
